@@ rtl/quaternion_point_rotator_core_macros.svh @@
// Assertion macros for the quaternion point rotator checker
`ifndef QUATERNION_POINT_ROTATOR_CORE_MACROS_SVH
`define QUATERNION_POINT_ROTATOR_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define QPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define QPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset too
`define QPR_ASSERT_ALW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qpr_pkg.sv @@
// Shared constants, types and tables of the quaternion point rotator
`timescale 1ns / 1ps
package qpr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 36;
    localparam int NUMW         = 61;
    localparam int DENW         = 35;
    localparam int QBITS        = 25;

    localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;

    localparam logic [QBITS-1:0] SAT_POS_MAG = 25'd8388607;
    localparam logic [QBITS-1:0] SAT_NEG_MAG = 25'd8388608;
    localparam logic [23:0]      SAT_HI      = 24'h7FFFFF;
    localparam logic [23:0]      SAT_LO      = 24'h800000;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] scalar;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
    } t_side;

    // arctan(2^-i), Q.30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:       v = 36'sh03243F6A8;
            1:       v = 36'sh01DAC6705;
            2:       v = 36'sh00FADBAFC;
            3:       v = 36'sh007F56EA6;
            4:       v = 36'sh003FEAB76;
            5:       v = 36'sh001FFD55B;
            6:       v = 36'sh000FFFAAA;
            7:       v = 36'sh0007FFF55;
            8:       v = 36'sh0003FFFEA;
            9:       v = 36'sh0001FFFFD;
            10:      v = 36'sh0000FFFFF;
            11:      v = 36'sh00007FFFF;
            12:      v = 36'sh00003FFFF;
            13:      v = 36'sh00001FFFF;
            14:      v = 36'sh00000FFFF;
            15:      v = 36'sh000007FFF;
            16:      v = 36'sh000003FFF;
            17:      v = 36'sh000001FFF;
            18:      v = 36'sh000000FFF;
            19:      v = 36'sh0000007FF;
            20:      v = 36'sh0000003FF;
            21:      v = 36'sh0000001FF;
            22:      v = 36'sh0000000FF;
            23:      v = 36'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/qpr_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cos and sin of the half angle
`timescale 1ns / 1ps
module qpr_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_angle,
    input  qpr_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic signed [16:0]   o_cos,
    output logic signed [16:0]   o_sin,
    output qpr_pkg::t_side       o_side
);
    localparam int N  = qpr_pkg::CORDIC_STEPS;
    localparam int CW = qpr_pkg::CW;

    logic [N:0]                r_v;
    logic                      r_vo;
    logic signed [CW-1:0]      r_x [0:N];
    logic signed [CW-1:0]      r_y [0:N];
    logic signed [CW-1:0]      r_z [0:N-1];
    logic                      r_flip [0:N];
    qpr_pkg::t_side            r_side [0:N];
    logic signed [16:0]        r_cos, r_sin;
    qpr_pkg::t_side            r_side_o;

    logic signed [CW-1:0]      n_z0;
    logic                      n_flip0;
    logic signed [CW-1:0]      w_z;
    logic signed [CW-1:0]      w_xf, w_yf, w_xr, w_yr;

    // half angle in Q.30, folded into [-pi/2, pi/2]
    always_comb begin
        w_z     = {{3{i_angle[15]}}, i_angle, 17'd0};
        n_z0    = w_z;
        n_flip0 = 1'b0;
        if (w_z > qpr_pkg::HALF_PI_Q30) begin
            n_z0    = w_z - qpr_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end else if (w_z < -qpr_pkg::HALF_PI_Q30) begin
            n_z0    = w_z + qpr_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[N-1:0], i_valid};
            r_vo <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= qpr_pkg::GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [CW-1:0] w_xs, w_ys;
        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                end else begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                end
                r_flip[i+1] <= r_flip[i];
                r_side[i+1] <= r_side[i];
            end
        end
        // the last step only needs the sign of its angle
        if (i < N - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[i+1] <= r_z[i][CW-1] ? (r_z[i] + qpr_pkg::atan_q30(i))
                                             : (r_z[i] - qpr_pkg::atan_q30(i));
                end
            end
        end
    end

    // undo the fold, then round Q.30 to Q.14
    always_comb begin
        w_xf = r_flip[N] ? -r_x[N] : r_x[N];
        w_yf = r_flip[N] ? -r_y[N] : r_y[N];
        w_xr = w_xf + 36'sd32768;
        w_yr = w_yf + 36'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos    <= w_xr[32:16];
            r_sin    <= w_yr[32:16];
            r_side_o <= r_side[N];
        end
    end

    assign o_valid = r_vo;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_side  = r_side_o;
endmodule

@@ rtl/qpr_matrix.sv @@
// Quaternion build, rotation matrix terms and products with the point
`timescale 1ns / 1ps
module qpr_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [16:0]            i_cos,
    input  logic signed [16:0]            i_sin,
    input  qpr_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [qpr_pkg::NUMW-1:0]      o_num [0:2],
    output logic [2:0]                    o_neg,
    output logic [qpr_pkg::DENW-1:0]      o_den,
    output logic                          o_zero
);
    localparam int NUMW = qpr_pkg::NUMW;
    localparam int DENW = qpr_pkg::DENW;

    logic [5:0] r_v;

    // stage 1: axis times sine
    logic signed [32:0]  r1_ax, r1_ay, r1_az;
    logic signed [16:0]  r1_cos;
    qpr_pkg::t_side      r1_side;
    // stage 2: quaternion parts
    logic signed [16:0]  r2_s, r2_x, r2_y, r2_z;
    logic signed [23:0]  r2_p [0:2];
    // stage 3: pair products
    logic signed [33:0]  r3_ss, r3_xx, r3_yy, r3_zz, r3_xy, r3_xz, r3_yz, r3_sx, r3_sy, r3_sz;
    logic signed [23:0]  r3_p [0:2];
    // stage 4: matrix terms
    logic signed [35:0]  r4_m [0:8];
    logic [DENW-1:0]     r4_den;
    logic signed [23:0]  r4_p [0:2];
    // stage 5: term times coordinate
    logic signed [59:0]  r5_t [0:8];
    logic [DENW-1:0]     r5_den;
    // stage 6: row sums as sign and magnitude plus half divisor
    logic [NUMW-1:0]     r6_num [0:2];
    logic [2:0]          r6_neg;
    logic [DENW-1:0]     r6_den;
    logic                r6_zero;

    logic signed [32:0]  w_rx, w_ry, w_rz;
    logic signed [35:0]  w_ss, w_xx, w_yy, w_zz, w_xy, w_xz, w_yz, w_sx, w_sy, w_sz, w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax   <= 33'(i_side.vx) * 33'(i_sin);
            r1_ay   <= 33'(i_side.vy) * 33'(i_sin);
            r1_az   <= 33'(i_side.vz) * 33'(i_sin);
            r1_cos  <= i_cos;
            r1_side <= i_side;
        end
    end

    always_comb begin
        w_rx = r1_ax + 33'sd8192;
        w_ry = r1_ay + 33'sd8192;
        w_rz = r1_az + 33'sd8192;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r1_side.req_type) begin
                r2_s <= r1_cos;
                r2_x <= w_rx[30:14];
                r2_y <= w_ry[30:14];
                r2_z <= w_rz[30:14];
            end else begin
                r2_s <= 17'(r1_side.scalar);
                r2_x <= 17'(r1_side.vx);
                r2_y <= 17'(r1_side.vy);
                r2_z <= 17'(r1_side.vz);
            end
            r2_p[0] <= r1_side.px;
            r2_p[1] <= r1_side.py;
            r2_p[2] <= r1_side.pz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ss <= 34'(r2_s) * 34'(r2_s);
            r3_xx <= 34'(r2_x) * 34'(r2_x);
            r3_yy <= 34'(r2_y) * 34'(r2_y);
            r3_zz <= 34'(r2_z) * 34'(r2_z);
            r3_xy <= 34'(r2_x) * 34'(r2_y);
            r3_xz <= 34'(r2_x) * 34'(r2_z);
            r3_yz <= 34'(r2_y) * 34'(r2_z);
            r3_sx <= 34'(r2_s) * 34'(r2_x);
            r3_sy <= 34'(r2_s) * 34'(r2_y);
            r3_sz <= 34'(r2_s) * 34'(r2_z);
            r3_p  <= r2_p;
        end
    end

    always_comb begin
        w_ss = 36'(r3_ss); w_xx = 36'(r3_xx); w_yy = 36'(r3_yy); w_zz = 36'(r3_zz);
        w_xy = 36'(r3_xy); w_xz = 36'(r3_xz); w_yz = 36'(r3_yz);
        w_sx = 36'(r3_sx); w_sy = 36'(r3_sy); w_sz = 36'(r3_sz);
        w_n  = w_ss + w_xx + w_yy + w_zz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_m[0] <= w_ss + w_xx - w_yy - w_zz;
            r4_m[1] <= (w_xy - w_sz) <<< 1;
            r4_m[2] <= (w_xz + w_sy) <<< 1;
            r4_m[3] <= (w_xy + w_sz) <<< 1;
            r4_m[4] <= w_ss - w_xx + w_yy - w_zz;
            r4_m[5] <= (w_yz - w_sx) <<< 1;
            r4_m[6] <= (w_xz - w_sy) <<< 1;
            r4_m[7] <= (w_yz + w_sx) <<< 1;
            r4_m[8] <= w_ss - w_xx - w_yy + w_zz;
            r4_den  <= w_n[DENW-1:0];
            r4_p    <= r3_p;
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r5_t[k] <= 60'(r4_m[k]) * 60'(r4_p[k % 3]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_den <= r4_den;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        logic signed [61:0] w_sum, w_mag;
        always_comb begin
            w_sum = 62'(r5_t[3*r]) + 62'(r5_t[3*r+1]) + 62'(r5_t[3*r+2]);
            w_mag = w_sum[61] ? -w_sum : w_sum;
        end
        // half divisor added up front gives round-half-away on the magnitude
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r6_num[r] <= w_mag[NUMW-1:0] + NUMW'(r5_den >> 1);
                r6_neg[r] <= w_sum[61];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_den  <= r5_den;
            r6_zero <= (r5_den == '0);
        end
    end

    assign o_valid = r_v[5];
    assign o_num   = r6_num;
    assign o_neg   = r6_neg;
    assign o_den   = r6_den;
    assign o_zero  = r6_zero;
endmodule

@@ rtl/qpr_divider.sv @@
// Three-lane pipelined restoring divider with saturation
`timescale 1ns / 1ps
module qpr_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [qpr_pkg::NUMW-1:0]      i_num [0:2],
    input  logic [2:0]                    i_neg,
    input  logic [qpr_pkg::DENW-1:0]      i_den,
    input  logic                          i_zero,
    output logic                          o_valid,
    output logic [23:0]                   o_rot [0:2],
    output logic                          o_zero
);
    localparam int NUMW = qpr_pkg::NUMW;
    localparam int DENW = qpr_pkg::DENW;
    localparam int QB   = qpr_pkg::QBITS;

    logic [QB:0]         r_v;
    logic [NUMW-1:0]     r_rem [0:QB-1][0:2];
    logic [QB-1:0]       r_q   [0:QB][0:2];
    logic [2:0]          r_ovf [0:QB];
    logic [2:0]          r_neg [0:QB];
    logic [DENW-1:0]     r_den [0:QB-1];
    logic                r_zero [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-1:0], i_valid};
        end
    end

    // entry: quotient beyond QB bits saturates, unless the zero flag forces zero
    for (genvar l = 0; l < 3; l++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][l] <= i_num[l];
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= (i_num[l] >= {1'b0, i_den, {QB{1'b0}}});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0]  <= i_neg;
            r_den[0]  <= i_den;
            r_zero[0] <= i_zero;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int B = QB - 1 - k;
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [NUMW-1:0] w_dsh;
            logic            w_ge;
            logic [QB-1:0]   w_q;
            always_comb begin
                w_dsh  = NUMW'(r_den[k]) << B;
                w_ge   = (r_rem[k][l] >= w_dsh);
                w_q    = r_q[k][l];
                w_q[B] = w_ge;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[k+1][l] <= w_q;
                end
            end
            if (k < QB - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k+1][l] <= w_ge ? (r_rem[k][l] - w_dsh) : r_rem[k][l];
                    end
                end
            end
        end
        if (k < QB - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k+1] <= r_den[k];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k+1]  <= r_ovf[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_sat
        logic [QB-1:0] w_q, w_nq;
        always_comb begin
            w_q  = r_q[QB][l];
            w_nq = '0 - w_q;
            if (r_zero[QB]) begin
                o_rot[l] = '0;
            end else if (r_neg[QB][l]) begin
                o_rot[l] = (r_ovf[QB][l] || (w_q > qpr_pkg::SAT_NEG_MAG))
                           ? qpr_pkg::SAT_LO : w_nq[23:0];
            end else begin
                o_rot[l] = (r_ovf[QB][l] || (w_q > qpr_pkg::SAT_POS_MAG))
                           ? qpr_pkg::SAT_HI : w_q[23:0];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_zero  = r_zero[QB];
endmodule

@@ rtl/quaternion_point_rotator_core.sv @@
// Throughput: one request per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken.
// Depth is set by the CORDIC steps, six matrix stages and a 26-stage divider per lane.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module quaternion_point_rotator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // quat_scalar, vec_x, vec_y, vec_z, angle (16 each), point_x, point_y, point_z (24 each)
    input  logic [151:0]  i_s_axis_tdata,
    // req_type
    input  logic          i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // rot_x, rot_y, rot_z (24 each)
    output logic [71:0]   o_m_axis_tdata,
    // zero_quat_error
    output logic          o_m_axis_tuser
);
    localparam int NUMW = qpr_pkg::NUMW;
    localparam int DENW = qpr_pkg::DENW;

    logic                 w_en;
    qpr_pkg::t_side       w_side_in, w_side_c;
    logic                 w_cv, w_mv, w_dv, w_dzero;
    logic signed [16:0]   w_cos, w_sin;
    logic [NUMW-1:0]      w_num [0:2];
    logic [2:0]           w_neg;
    logic [DENW-1:0]      w_den;
    logic                 w_mzero;
    logic [23:0]          w_rot [0:2];

    logic                 r_out_valid;
    logic [71:0]          r_out_data;
    logic                 r_out_err;

    assign w_en = !r_out_valid || i_m_axis_tready;

    always_comb begin
        w_side_in.req_type = i_s_axis_tuser;
        w_side_in.scalar   = i_s_axis_tdata[15:0];
        w_side_in.vx       = i_s_axis_tdata[31:16];
        w_side_in.vy       = i_s_axis_tdata[47:32];
        w_side_in.vz       = i_s_axis_tdata[63:48];
        w_side_in.px       = i_s_axis_tdata[103:80];
        w_side_in.py       = i_s_axis_tdata[127:104];
        w_side_in.pz       = i_s_axis_tdata[151:128];
    end

    qpr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_angle (i_s_axis_tdata[79:64]),
        .i_side  (w_side_in),
        .o_valid (w_cv),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_side  (w_side_c)
    );

    qpr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_side  (w_side_c),
        .o_valid (w_mv),
        .o_num   (w_num),
        .o_neg   (w_neg),
        .o_den   (w_den),
        .o_zero  (w_mzero)
    );

    qpr_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mv),
        .i_num   (w_num),
        .i_neg   (w_neg),
        .i_den   (w_den),
        .i_zero  (w_mzero),
        .o_valid (w_dv),
        .o_rot   (w_rot),
        .o_zero  (w_dzero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {w_rot[2], w_rot[1], w_rot[0]};
            r_out_err  <= w_dzero;
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_err;
endmodule

@@ rtl/qpr_checker.sv @@
// Port-level checks of the quaternion point rotator, bound to the top level
`timescale 1ns / 1ps
`include "quaternion_point_rotator_core_macros.svh"
module qpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] i_m_tdata,
    input logic        i_m_tuser
);
    `QPR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "output request dropped while stalled")
    `QPR_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tuser, i_m_tdata == 72'd0, "zero quaternion result not zero")
    `QPR_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !i_m_tvalid || i_m_tready, i_s_tready, "input stalled with free output")
    `QPR_ASSERT_ALW(a_rst_clear, i_clk, !i_rst_n, !i_m_tvalid, "output valid after reset")
endmodule

bind quaternion_point_rotator_core qpr_checker u_qpr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

@@ verif/quaternion_point_rotator_core_checker.sv @@
// Stream monitor with rotation predictor and scoreboard for the quaternion point rotator
`timescale 1ns / 1ps
module quaternion_point_rotator_core_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [151:0] i_s_data,
    input  logic         i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [71:0]  i_m_data,
    input  logic         i_m_user,
    output int           o_fail_cnt,
    output int           o_pending
);
    localparam longint GAIN = 64'sd652032874;
    localparam longint HPI  = 64'sd1686629713;
    localparam longint PI   = 64'sd3373259426;

    typedef struct packed {
        logic [23:0] rx;
        logic [23:0] ry;
        logic [23:0] rz;
        logic        zq;
    } t_rot;

    t_rot rot_q[$];
    int   fails = 0;
    int   pend = 0;

    assign o_fail_cnt = fails;
    assign o_pending  = pend;

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [23:0] quot_round_sat(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0)
            return (q > 8388608) ? 24'h800000 : 24'(-q);
        return (q > 8388607) ? 24'h7FFFFF : 24'(q);
    endfunction

    function automatic t_rot rotate_point(logic mode, logic [151:0] d);
        longint s, x, y, z, ax, ay, az, px, py, pz, n, ang, zc, cx, cy, nx;
        longint ss, xx, yy, zz, xy, xz, yz, sx, sy, sz;
        bit flip;
        int steps;
        t_rot r;
        ax = longint'($signed(d[31:16]));
        ay = longint'($signed(d[47:32]));
        az = longint'($signed(d[63:48]));
        ang = longint'($signed(d[79:64]));
        px = longint'($signed(d[103:80]));
        py = longint'($signed(d[127:104]));
        pz = longint'($signed(d[151:128]));
        if (mode) begin
            zc = ang * 131072;
            cx = GAIN;
            cy = 0;
            flip = 0;
            if (zc > HPI) begin
                zc -= PI;
                flip = 1;
            end else if (zc < -HPI) begin
                zc += PI;
                flip = 1;
            end
            steps = (qpr_pkg::CORDIC_STEPS > 24) ? 24 : qpr_pkg::CORDIC_STEPS;
            for (int i = 0; i < steps; i++) begin
                if (zc >= 0) begin
                    nx = cx - fl_shift(cy, i);
                    cy = cy + fl_shift(cx, i);
                    zc -= longint'(qpr_pkg::atan_q30(i));
                end else begin
                    nx = cx + fl_shift(cy, i);
                    cy = cy - fl_shift(cx, i);
                    zc += longint'(qpr_pkg::atan_q30(i));
                end
                cx = nx;
            end
            if (flip) begin
                cx = -cx;
                cy = -cy;
            end
            s = fl_shift(cx + 32768, 16);
            cy = fl_shift(cy + 32768, 16);
            x = fl_shift(ax * cy + 8192, 14);
            y = fl_shift(ay * cy + 8192, 14);
            z = fl_shift(az * cy + 8192, 14);
        end else begin
            s = longint'($signed(d[15:0]));
            x = ax;
            y = ay;
            z = az;
        end
        ss = s * s; xx = x * x; yy = y * y; zz = z * z;
        n = ss + xx + yy + zz;
        if (n == 0) begin
            r = '{24'd0, 24'd0, 24'd0, 1'b1};
            return r;
        end
        xy = x * y; xz = x * z; yz = y * z;
        sx = s * x; sy = s * y; sz = s * z;
        r.rx = quot_round_sat((ss + xx - yy - zz) * px + 2 * (xy - sz) * py
                              + 2 * (xz + sy) * pz, n);
        r.ry = quot_round_sat(2 * (xy + sz) * px + (ss - xx + yy - zz) * py
                              + 2 * (yz - sx) * pz, n);
        r.rz = quot_round_sat(2 * (xz - sy) * px + 2 * (yz + sx) * py
                              + (ss - xx - yy + zz) * pz, n);
        r.zq = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rot want;
        if (i_rst_n) begin
            if (i_s_valid && i_s_ready)
                rot_q.push_back(rotate_point(i_s_user, i_s_data));
            if (i_m_valid && i_m_ready) begin
                if (rot_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result %h/%b", $time, i_m_data, i_m_user);
                end else begin
                    want = rot_q.pop_front();
                    if (want.rx !== i_m_data[23:0] || want.ry !== i_m_data[47:24]
                        || want.rz !== i_m_data[71:48] || want.zq !== i_m_user) begin
                        fails++;
                        $display("%0t: mismatch expected %h %h %h err %b, got %h %h %h err %b",
                                 $time, want.rx, want.ry, want.rz, want.zq,
                                 i_m_data[23:0], i_m_data[47:24], i_m_data[71:48],
                                 i_m_user);
                    end
                end
            end
            pend = rot_q.size();
        end
    end
endmodule

@@ verif/quaternion_point_rotator_core_tb.sv @@
// Testbench top: request stimulus, output back-pressure and the final verdict
`timescale 1ns / 1ps
module quaternion_point_rotator_core_tb;
    localparam int N_RAND    = 1250;
    localparam int LATENCY   = 51;
    localparam int MAX_CYCLE = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid, s_ready, s_user;
    logic [151:0] s_data;
    logic         m_valid, m_ready, m_user;
    logic [71:0]  m_data;
    int           fail_cnt, pending;
    int           cycle = 0;
    bit           calm;

    quaternion_point_rotator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    quaternion_point_rotator_core_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_user(s_user),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one request; random idle gaps before it unless calm, held until accepted
    task automatic send_req(logic mode, logic [15:0] sc, logic [15:0] vx, logic [15:0] vy,
                            logic [15:0] vz, logic [15:0] ang, logic [23:0] px,
                            logic [23:0] py, logic [23:0] pz);
        while (!calm && $urandom_range(99) < 33) begin
            s_valid <= 0;
            @(negedge i_clk);
        end
        s_valid <= 1;
        s_user  <= mode;
        s_data  <= {pz, py, px, ang, vz, vy, vx, sc};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [23:0] rnd_pt(int k);
        case (k)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(int'($urandom_range(16384)) - 8192);
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off while requests keep coming
    initial begin
        int rx_cyc;
        rx_cyc = 0;
        m_ready <= 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cyc++;
            if (rx_cyc > 300 && rx_cyc <= 700)
                m_ready <= 0;
            else
                m_ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    initial begin
        logic [15:0] a;
        int unsigned k;
        calm = 0;
        i_rst_n = 0;
        s_valid = 0;
        s_user = 0;
        s_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // directed
        send_req(0, 16'h4000, 0, 0, 0, 0, 24'h001000, 24'h002000, 24'h003000);
        send_req(0, 0, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000, 24'h001000);
        send_req(1, 0, 0, 0, 0, 16'h1234, 24'h001000, 24'h001000, 24'h001000);
        send_req(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0,
                 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_req(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0,
                 24'h800000, 24'h800000, 24'h800000);
        send_req(0, 0, 16'h0001, 0, 0, 0, 24'h800000, 24'h7FFFFF, 24'h000001);
        send_req(0, 16'h0001, 16'h0001, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_req(1, 16'hFFFF, 16'h4000, 0, 0, 16'h7FFF, 24'h001000, 24'h002000, 24'h0);
        send_req(1, 0, 0, 16'h4000, 0, 16'h8000, 24'h001000, 24'h002000, 24'h0);
        send_req(1, 0, 0, 0, 16'h4000, 16'h1922, 24'h001000, 24'h002000, 24'h003000);
        send_req(1, 0, 0, 0, 16'h4000, 16'hE6DE, 24'h001000, 24'h002000, 24'h003000);
        send_req(1, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h3244, 24'h7FFFFF, 24'h0, 24'h800000);
        send_req(1, 0, 16'h4000, 0, 0, 0, 24'h001000, 24'h0, 24'h0);
        // random
        for (int i = 0; i < N_RAND; i++) begin
            calm = (i >= 500 && i < 650);
            k = $urandom_range(9);
            a = (k < 2) ? 16'($urandom_range(32767) - 16384) : 16'($urandom);
            send_req($urandom_range(1),
                     (k == 9) ? 16'h0 : 16'($urandom),
                     (k == 9) ? 16'h0 : 16'($urandom),
                     (k == 9) ? 16'h0 : 16'($urandom),
                     (k == 9) ? 16'h0 : 16'($urandom), a,
                     rnd_pt($urandom_range(5)), rnd_pt($urandom_range(5)),
                     rnd_pt($urandom_range(5)));
        end
        s_valid <= 0;
        calm = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

@@ quaternion_point_rotator_core.f @@
+incdir+rtl
rtl/qpr_pkg.sv
rtl/qpr_cordic.sv
rtl/qpr_matrix.sv
rtl/qpr_divider.sv
rtl/quaternion_point_rotator_core.sv
rtl/qpr_checker.sv
verif/quaternion_point_rotator_core_checker.sv
verif/quaternion_point_rotator_core_tb.sv
